// File: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // default sizing
   localparam int GRANULE_BYTES_DEFAULT = 64;
   localparam int HEADER_BYTES_DEFAULT  = 16;
   localparam int MAX_GRANULES_DEFAULT  = 4096;

   // request kinds
   localparam logic [1:0] KIND_ALLOC_GRANULES = 2'd0;
   localparam logic [1:0] KIND_ALLOC_BYTES    = 2'd1;
   localparam logic [1:0] KIND_FREE           = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NULL     = 2'd1;
   localparam logic [1:0] STATUS_BAD_PTR  = 2'd2;
   localparam logic [1:0] STATUS_NO_FIT   = 2'd3;

   // register map
   localparam int         CSR_INDEX_WIDTH   = 1;
   localparam logic [0:0] CSR_HEAP_BASE     = 1'b0;
   localparam logic [0:0] CSR_HEAP_GRANULES = 1'b1;
   localparam int         CSR_DATA_WIDTH    = 64;
   localparam logic [12:0] HEAP_GRANULES_RESET = 13'd4096;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] granule_count;
      logic [31:0] byte_count;
      logic [63:0] pointer;
   } req_type;

   typedef struct packed {
      logic [63:0] address;
      logic [1:0]  status;
   } rsp_type;

endpackage

// File: rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over an address-ordered free list held in
// per-granule link and size memories, with split on allocate and
// coalescing on free.
// ----------------------------------------------------------------------------
// Allocate reads and checks each free extent visited, then writes the split
//   remainder, predecessor link and block link, or closes with no fit. Free
//   checks the pointer, walks past lower extents, links the block in and
//   merges. Zero counts, null frees and unused kinds answer in the cycle after
//   start. One request at a time; the list walk through the registered-read
//   memories sets the rate. The result is a one-cycle strobe that the receiver
//   cannot stall. Reset is synchronous and clears control state only.
module first_fit_block_allocator #(
   parameter int GRANULE_BYTES = ffba_pkg::GRANULE_BYTES_DEFAULT,
   parameter int HEADER_BYTES  = ffba_pkg::HEADER_BYTES_DEFAULT,
   parameter int MAX_GRANULES  = ffba_pkg::MAX_GRANULES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  ffba_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   output ffba_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ffba_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ffba_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   localparam int IW = $clog2(MAX_GRANULES + 1);
   localparam int AW = $clog2(MAX_GRANULES);
   localparam int SW = $clog2(MAX_GRANULES + 2);
   localparam int GS = $clog2(GRANULE_BYTES);
   localparam int NW = 33;
   localparam logic [IW-1:0] NONE       = IW'(MAX_GRANULES);
   localparam logic [SW-1:0] WALK_LIMIT = SW'(MAX_GRANULES + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_A_ISSUE, S_A_EVAL, S_A_W1, S_A_W2, S_A_W3,
      S_F_CHK1, S_F_CHK2, S_F_ISSUE, S_F_EVAL, S_F_INS, S_F_INS2,
      S_M_ISSUE, S_M_EVAL, S_M_JOIN
   } state_type;

   state_type         state_ff;
   logic [63:0]       heap_base_ff;
   logic [12:0]       heap_granules_ff;
   logic [IW-1:0]     head_ff;
   logic              init_ff;
   logic [IW-1:0]     cur_ff, prev_ff, nb_ff, g_ff, r_ff, lk_ff, sz_ff;
   logic [NW-1:0]     n_ff;
   logic [SW-1:0]     steps_ff;
   logic              split_ff, second_ff;
   logic [63:0]       off_ff;
   logic              rsp_valid_ff;
   ffba_pkg::rsp_type rsp_ff;

   // link and size memories
   logic [IW-1:0] link_mem [MAX_GRANULES];
   logic [IW-1:0] size_mem [MAX_GRANULES];
   logic [IW-1:0] link_q_ff, size_q_ff;
   logic          rd_oob_ff;
   logic [IW-1:0] rd_addr, link_wa, link_wd, size_wa, size_wd;
   logic          link_we, size_we;

   logic          accept;
   logic [IW-1:0] len;
   logic [IW-1:0] lk, sz;
   logic [32:0]   total;
   logic [NW-1:0] n_bytes, n_req;
   logic [64:0]   base_diff;
   logic [63:0]   limit;
   logic          alloc_kind;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // heap length clamped to the store depth
   assign len = (32'(heap_granules_ff) < 32'(MAX_GRANULES)) ?
                IW'(heap_granules_ff) : NONE;

   // read data, out-of-range entries read as no link and size zero
   assign lk = rd_oob_ff ? NONE : link_q_ff;
   assign sz = rd_oob_ff ? '0   : size_q_ff;

   // byte request rounded up to granules with the header added
   assign total   = {1'b0, req_item.byte_count} + 33'(HEADER_BYTES);
   assign n_bytes = NW'(total >> GS) + NW'(|total[GS-1:0]);
   assign n_req   = (req_item.kind == ffba_pkg::KIND_ALLOC_GRANULES) ?
                    NW'(req_item.granule_count) : n_bytes;
   assign alloc_kind = (req_item.kind == ffba_pkg::KIND_ALLOC_GRANULES) ||
                       (req_item.kind == ffba_pkg::KIND_ALLOC_BYTES);

   assign base_diff = {1'b0, off_ff} - {1'b0, heap_base_ff};
   assign limit     = 64'(len) << GS;

   // memory port control
   always_comb begin
      rd_addr = cur_ff;
      link_we = 1'b0;
      link_wa = cur_ff;
      link_wd = NONE;
      size_we = 1'b0;
      size_wa = cur_ff;
      size_wd = sz_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && alloc_kind && !init_ff && (len != '0)) begin
               link_we = 1'b1;
               link_wa = '0;
               link_wd = NONE;
               size_we = 1'b1;
               size_wa = '0;
               size_wd = len;
            end
         end
         S_A_W1: begin
            link_we = 1'b1;
            link_wa = nb_ff;
            link_wd = lk_ff;
            size_we = 1'b1;
            size_wa = nb_ff;
            size_wd = sz_ff - n_ff[IW-1:0];
         end
         S_A_W2: begin
            size_we = split_ff;
            size_wa = cur_ff;
            size_wd = n_ff[IW-1:0];
            link_we = (prev_ff != NONE);
            link_wa = prev_ff;
            link_wd = split_ff ? nb_ff : lk_ff;
         end
         S_A_W3: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = NONE;
         end
         S_F_INS: begin
            link_we = 1'b1;
            link_wa = g_ff;
            link_wd = (prev_ff == NONE) ? head_ff : cur_ff;
         end
         S_F_INS2: begin
            link_we = 1'b1;
            link_wa = prev_ff;
            link_wd = g_ff;
         end
         S_M_ISSUE: begin
            rd_addr = r_ff;
         end
         S_M_EVAL: begin
            rd_addr = lk;
         end
         S_M_JOIN: begin
            link_we = 1'b1;
            link_wa = r_ff;
            link_wd = lk;
            size_we = 1'b1;
            size_wa = r_ff;
            size_wd = sz_ff + sz;
         end
         default: begin
            rd_addr = cur_ff;
         end
      endcase
   end

   // memories: drop writes beyond the store, register read data
   always_ff @(posedge clock) begin
      if (link_we && (link_wa < NONE)) begin
         link_mem[link_wa[AW-1:0]] <= link_wd;
      end
      if (size_we && (size_wa < NONE)) begin
         size_mem[size_wa[AW-1:0]] <= size_wd;
      end
      link_q_ff <= link_mem[rd_addr[AW-1:0]];
      size_q_ff <= size_mem[rd_addr[AW-1:0]];
      rd_oob_ff <= (rd_addr >= NONE);
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         heap_base_ff     <= '0;
         heap_granules_ff <= ffba_pkg::HEAP_GRANULES_RESET;
         head_ff          <= '0;
         init_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         // register writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ffba_pkg::CSR_HEAP_BASE:     heap_base_ff     <= csr_data;
               ffba_pkg::CSR_HEAP_GRANULES: heap_granules_ff <= csr_data[12:0];
               default:                     heap_base_ff     <= heap_base_ff;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (alloc_kind) begin
                     if (!init_ff) begin
                        init_ff <= 1'b1;
                        head_ff <= (len != '0) ? '0 : NONE;
                     end
                     if (n_req == '0) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_NO_FIT};
                     end else begin
                        n_ff     <= n_req;
                        cur_ff   <= init_ff ? head_ff : ((len != '0) ? '0 : NONE);
                        prev_ff  <= NONE;
                        steps_ff <= '0;
                        state_ff <= S_A_ISSUE;
                     end
                  end else if (req_item.kind == ffba_pkg::KIND_FREE) begin
                     if (req_item.pointer == '0) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_NULL};
                     end else begin
                        off_ff   <= req_item.pointer - 64'(HEADER_BYTES);
                        state_ff <= S_F_CHK1;
                     end
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_OK};
                  end
               end
            end

            // walk the list until an extent fits
            S_A_ISSUE: begin
               if ((cur_ff != NONE) && (steps_ff < WALK_LIMIT)) begin
                  state_ff <= S_A_EVAL;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_NO_FIT};
                  state_ff <= S_IDLE;
               end
            end
            S_A_EVAL: begin
               steps_ff <= steps_ff + 1'b1;
               lk_ff    <= lk;
               sz_ff    <= sz;
               if (NW'(sz) < n_ff) begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= lk;
                  state_ff <= S_A_ISSUE;
               end else begin
                  split_ff <= (NW'(sz) != n_ff);
                  nb_ff    <= cur_ff + n_ff[IW-1:0];
                  off_ff   <= (64'(cur_ff) << GS) + 64'(HEADER_BYTES);
                  state_ff <= (NW'(sz) != n_ff) ? S_A_W1 : S_A_W2;
               end
            end
            S_A_W1: begin
               state_ff <= S_A_W2;
            end
            S_A_W2: begin
               if (prev_ff == NONE) begin
                  head_ff <= split_ff ? nb_ff : lk_ff;
               end
               state_ff <= S_A_W3;
            end
            S_A_W3: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff <= '{address: heap_base_ff + off_ff, status: ffba_pkg::STATUS_OK};
               state_ff <= S_IDLE;
            end

            // pointer checks
            S_F_CHK1: begin
               if (base_diff[64]) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_BAD_PTR};
                  state_ff <= S_IDLE;
               end else begin
                  off_ff   <= base_diff[63:0];
                  state_ff <= S_F_CHK2;
               end
            end
            S_F_CHK2: begin
               if ((off_ff >= limit) || (off_ff[GS-1:0] != '0)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_BAD_PTR};
                  state_ff <= S_IDLE;
               end else begin
                  g_ff     <= IW'(off_ff >> GS);
                  cur_ff   <= head_ff;
                  prev_ff  <= NONE;
                  steps_ff <= '0;
                  state_ff <= S_F_ISSUE;
               end
            end

            // find the insertion point
            S_F_ISSUE: begin
               if ((cur_ff != NONE) && (cur_ff < g_ff) && (steps_ff < WALK_LIMIT)) begin
                  state_ff <= S_F_EVAL;
               end else begin
                  state_ff <= S_F_INS;
               end
            end
            S_F_EVAL: begin
               prev_ff  <= cur_ff;
               cur_ff   <= lk;
               steps_ff <= steps_ff + 1'b1;
               state_ff <= S_F_ISSUE;
            end
            S_F_INS: begin
               if (prev_ff == NONE) begin
                  head_ff   <= g_ff;
                  r_ff      <= g_ff;
                  second_ff <= 1'b0;
                  state_ff  <= S_M_ISSUE;
               end else begin
                  state_ff <= S_F_INS2;
               end
            end
            S_F_INS2: begin
               r_ff      <= g_ff;
               second_ff <= 1'b0;
               state_ff  <= S_M_ISSUE;
            end

            // merge the freed block forward, then its predecessor
            S_M_ISSUE: begin
               if (r_ff != NONE) begin
                  state_ff <= S_M_EVAL;
               end else if (!second_ff) begin
                  r_ff      <= prev_ff;
                  second_ff <= 1'b1;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_OK};
                  state_ff <= S_IDLE;
               end
            end
            S_M_EVAL: begin
               sz_ff <= sz;
               if ((lk != NONE) && ((IW+1)'(r_ff) + (IW+1)'(sz) == (IW+1)'(lk))) begin
                  state_ff <= S_M_JOIN;
               end else if (!second_ff) begin
                  r_ff      <= prev_ff;
                  second_ff <= 1'b1;
                  state_ff  <= S_M_ISSUE;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_OK};
                  state_ff <= S_IDLE;
               end
            end
            S_M_JOIN: begin
               if (!second_ff) begin
                  r_ff      <= prev_ff;
                  second_ff <= 1'b1;
                  state_ff  <= S_M_ISSUE;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{address: '0, status: ffba_pkg::STATUS_OK};
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit block allocator.
// ----------------------------------------------------------------------------
module ffba_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ffba_pkg::rsp_type rsp_item,
   input logic              csr_ready
);

   // an accepted request either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither answered nor in progress");

   // no result beat without a request behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result beat without a request");

   // failing results carry a null address
   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ffba_pkg::STATUS_OK)) |-> (rsp_item.address == '0))
      else $error("failing result with non-null address");

   // configuration is refused while a request is in flight
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready)
      else $error("configuration ready while busy");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item),
   .csr_ready (csr_ready)
);
